### src/msett_pkg.sv
// Shared types and codes for the multi-slot expiry timer table.
// Used by the slot RAM and the top level; depends on nothing.
package msett_pkg;

   localparam logic [2:0] CMD_TICK      = 3'd0;
   localparam logic [2:0] CMD_INSTALL   = 3'd1;
   localparam logic [2:0] CMD_UNINSTALL = 3'd2;
   localparam logic [2:0] CMD_NEW_DUR   = 3'd3;
   localparam logic [2:0] CMD_PERIODIC  = 3'd4;
   localparam logic [2:0] CMD_QUERY     = 3'd5;

   localparam logic [1:0] KIND_INSTALL = 2'd0;
   localparam logic [1:0] KIND_EXPIRY  = 2'd1;
   localparam logic [1:0] KIND_QUERY   = 2'd2;
   localparam logic [1:0] KIND_ACK     = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   // most expiry events reported per tick
   localparam int MAX_RESULTS = 8;
   localparam int CNT_W       = 4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [7:0]  slot_number;
      logic [31:0] elapsed;
      logic [31:0] remaining;
      logic [31:0] start_stamp;
      logic        last;
   } result_type;

   typedef struct packed {
      logic dur_we;
      logic stamp_we;
   } ram_wr_type;

endpackage

### src/multi_slot_expiry_timer_table.sv
// Multi-slot expiry timer table: a sequencer over one slot compare unit and a slot RAM.
// Tick: compares every slot, one slot per cycle while no expiry waits for rsp_tready,
// then flushes the held-back event. Install: free-slot search, one slot per cycle.
// Slot commands give one result, unknown ones none. Results wait for rsp_tready.
// One request at a time; ready only while idle. Reset clears the time counter and the
// used/periodic bits; the slot RAM has no reset, an entry is written at install first.
module multi_slot_expiry_timer_table import msett_pkg::*; #(
   parameter int SLOT_COUNT = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [7:0] slot_id, [39:8] duration, [40] periodic, [47:41] zero
   input  logic [47:0]   req_tdata,
   // [2:0] cmd
   input  logic [2:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [1:0] status, [9:2] slot_number, [41:10] elapsed, [73:42] remaining,
   // [105:74] start_stamp, [111:106] zero
   output logic [111:0]  rsp_tdata,
   // [1:0] kind
   output logic [1:0]    rsp_tuser,
   output logic          rsp_tlast
);

   localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [7:0]    SLOT_LIMIT = 8'(SLOT_COUNT);
   localparam logic [IW-1:0] LAST_IDX   = IW'(SLOT_COUNT - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CMD   = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_FLUSH = 3'd3;
   localparam logic [2:0] ST_FIND  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [2:0]            cmd_ff;
   logic [7:0]            id_ff;
   logic [31:0]           dur_ff;
   logic                  per_ff;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [31:0]           now_ff, now_in;
   logic [SLOT_COUNT-1:0] used_ff, used_in;
   logic [SLOT_COUNT-1:0] per_bits_ff, per_bits_in;
   logic                  pend_valid_ff, pend_valid_in;
   result_type            pend_ff, pend_in;
   logic                  rsp_valid_ff;
   result_type            rsp_ff, rsp_in;
   logic                  rsp_load;

   logic                  req_accept;
   logic                  out_free;
   logic [IW-1:0]         id_idx;
   logic                  id_valid;
   logic                  id_live;
   logic [IW-1:0]         rd_addr;
   logic [31:0]           rd_dur;
   logic [31:0]           rd_stamp;
   logic [31:0]           elapsed;
   logic [31:0]           remaining;
   logic                  hit;
   logic                  scan_stall;
   result_type            res_new;
   ram_wr_type            wr_en;
   logic [IW-1:0]         wr_addr;
   logic [31:0]           wr_dur;
   logic [31:0]           wr_stamp;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign id_idx   = id_ff[IW-1:0];
   assign id_valid = (id_ff < SLOT_LIMIT);
   assign id_live  = id_valid && used_ff[id_idx];

   // shared compare unit: works on whichever slot the RAM just returned
   assign elapsed   = now_ff - rd_stamp;
   assign remaining = rd_dur - elapsed;
   assign hit       = used_ff[idx_ff] && (elapsed >= rd_dur);
   assign scan_stall = hit && (cnt_ff < CNT_W'(MAX_RESULTS)) && pend_valid_ff && !out_free;

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            rd_addr = (req_tuser == CMD_TICK) ? '0 : req_tdata[IW-1:0];
         end
         ST_CMD: begin
            rd_addr = id_idx;
         end
         ST_SCAN: begin
            rd_addr = scan_stall ? idx_ff : idx_ff + 1'b1;
         end
         default: begin
            rd_addr = idx_ff;
         end
      endcase
   end

   msett_slot_ram #(
      .SLOT_COUNT (SLOT_COUNT),
      .ADDR_W     (IW)
   ) u_slot_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_dur   (wr_dur),
      .wr_stamp (wr_stamp),
      .rd_addr  (rd_addr),
      .rd_dur   (rd_dur),
      .rd_stamp (rd_stamp)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      now_in        = now_ff;
      used_in       = used_ff;
      per_bits_in   = per_bits_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_load      = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = '0;
      wr_addr       = idx_ff;
      wr_dur        = dur_ff;
      wr_stamp      = now_ff;
      res_new       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               idx_in = '0;
               cnt_in = '0;
               case (req_tuser)
                  CMD_TICK: begin
                     now_in   = now_ff + 32'd1;
                     state_in = ST_SCAN;
                  end
                  CMD_INSTALL: begin
                     state_in = ST_FIND;
                  end
                  CMD_UNINSTALL, CMD_NEW_DUR, CMD_PERIODIC, CMD_QUERY: begin
                     state_in = ST_CMD;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_CMD: begin
            res_new.slot_number = id_ff;
            res_new.last        = 1'b1;
            res_new.kind        = KIND_ACK;
            res_new.status      = id_live ? STATUS_OK : STATUS_INVALID;
            case (cmd_ff)
               CMD_UNINSTALL: begin
                  res_new.status = id_valid ? STATUS_OK : STATUS_INVALID;
               end
               CMD_QUERY: begin
                  res_new.kind = KIND_QUERY;
                  if (id_live) begin
                     res_new.elapsed     = elapsed;
                     res_new.remaining   = remaining;
                     res_new.start_stamp = rd_stamp;
                  end
               end
               default: begin
               end
            endcase
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_in   = res_new;
               state_in = ST_IDLE;
               case (cmd_ff)
                  CMD_UNINSTALL: begin
                     if (id_valid) begin
                        used_in[id_idx]     = 1'b0;
                        per_bits_in[id_idx] = 1'b0;
                     end
                  end
                  CMD_NEW_DUR: begin
                     wr_addr      = id_idx;
                     wr_en.dur_we = id_live;
                  end
                  CMD_PERIODIC: begin
                     if (id_live) begin
                        per_bits_in[id_idx] = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_FIND: begin
            res_new.kind = KIND_INSTALL;
            res_new.last = 1'b1;
            if (!used_ff[idx_ff]) begin
               res_new.status      = STATUS_OK;
               res_new.slot_number = 8'(idx_ff);
               res_new.remaining   = dur_ff;
               res_new.start_stamp = now_ff;
               if (out_free) begin
                  rsp_load            = 1'b1;
                  rsp_in              = res_new;
                  used_in[idx_ff]     = 1'b1;
                  per_bits_in[idx_ff] = per_ff;
                  wr_en.dur_we        = 1'b1;
                  wr_en.stamp_we      = 1'b1;
                  state_in            = ST_IDLE;
               end
            end else if (idx_ff == LAST_IDX) begin
               res_new.status = STATUS_FULL;
               if (out_free) begin
                  rsp_load = 1'b1;
                  rsp_in   = res_new;
                  state_in = ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_SCAN: begin
            res_new.kind        = KIND_EXPIRY;
            res_new.status      = STATUS_OK;
            res_new.slot_number = 8'(idx_ff);
            res_new.elapsed     = elapsed;
            res_new.remaining   = remaining;
            res_new.start_stamp = rd_stamp;
            if (!scan_stall) begin
               if (hit) begin
                  if (cnt_ff < CNT_W'(MAX_RESULTS)) begin
                     // hold the newest event back until it is known whether it is the last
                     if (pend_valid_ff) begin
                        rsp_load = 1'b1;
                        rsp_in   = pend_ff;
                     end
                     pend_in       = res_new;
                     pend_valid_in = 1'b1;
                     cnt_in        = cnt_ff + 1'b1;
                  end
                  if (per_bits_ff[idx_ff]) begin
                     wr_en.stamp_we = 1'b1;
                  end else begin
                     used_in[idx_ff]     = 1'b0;
                     per_bits_in[idx_ff] = 1'b0;
                  end
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_load      = 1'b1;
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         now_ff        <= '0;
         used_ff       <= '0;
         per_bits_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         now_ff        <= now_in;
         used_ff       <= used_in;
         per_bits_ff   <= per_bits_in;
         pend_valid_ff <= pend_valid_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff <= req_tuser;
         id_ff  <= req_tdata[7:0];
         dur_ff <= req_tdata[39:8];
         per_ff <= req_tdata[40];
      end
      pend_ff <= pend_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {6'd0, rsp_ff.start_stamp, rsp_ff.remaining, rsp_ff.elapsed,
                        rsp_ff.slot_number, rsp_ff.status};

endmodule

### src/msett_slot_ram.sv
// Per-slot duration and start stamp storage, one write and one registered read port.
// Depends on msett_pkg for the write-enable struct.
module msett_slot_ram import msett_pkg::*; #(
   parameter int SLOT_COUNT = 8,
   parameter int ADDR_W     = 3
) (
   input  logic              clock,
   input  ram_wr_type        wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_dur,
   input  logic [31:0]       wr_stamp,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       rd_dur,
   output logic [31:0]       rd_stamp
);

   logic [31:0] dur_mem [SLOT_COUNT];
   logic [31:0] stamp_mem [SLOT_COUNT];
   logic [31:0] rd_dur_ff;
   logic [31:0] rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (wr_en.dur_we) begin
         dur_mem[wr_addr] <= wr_dur;
      end
      if (wr_en.stamp_we) begin
         stamp_mem[wr_addr] <= wr_stamp;
      end
      rd_dur_ff   <= dur_mem[rd_addr];
      rd_stamp_ff <= stamp_mem[rd_addr];
   end

   assign rd_dur   = rd_dur_ff;
   assign rd_stamp = rd_stamp_ff;

endmodule
